@@ hw/rtl/i2cstc_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C SCL timing calculator package
// Constants shared by the timing calculator and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cstc_pkg;

  localparam int unsigned ClkW  = 29;
  localparam int unsigned RateW = 23;

  localparam logic [ClkW-1:0]  ClkReset      = 29'd125000000;
  localparam logic [RateW-1:0] FastThreshold = 23'd110000;
  localparam logic [RateW-1:0] HoldThreshold = 23'd600000;
  localparam logic [30:0]      MinPeriod     = 31'd23;
  localparam logic [15:0]      HighMax       = 16'd65525;

  // Reciprocals for the constant divisions. The 300 ns hold divides 3*clk by
  // 10^7 as (3*clk >> 7) / 78125, the 120 ns hold divides 3*clk by 2.5*10^7
  // as (3*clk >> 6) / 390625, and the low split takes 3*period / 5. Each
  // multiplier is ceil(2^k / d) (tripled for d = 5), exact over the full range.
  localparam logic [24:0] HoldMulStd  = 25'd28147498;     // k = 41
  localparam logic [25:0] HoldMulFast = 26'd45035997;     // k = 44
  localparam logic [33:0] LowMul3     = 34'd10307921511;  // 3 * ceil(2^34 / 5)

  localparam logic [1:0] ModeInvalid  = 2'd0;
  localparam logic [1:0] ModeStandard = 2'd1;
  localparam logic [1:0] ModeFast     = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/i2cstc_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage, with a sideband word and a valid bit
// that travel along with each division.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cstc_div #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 4,
  parameter int unsigned SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [NW-1:0]      quo_o,
  output logic [SW-1:0]      side_o
);

  logic          vld_q  [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] num_q  [NW];
  logic [NW-1:0] quo_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] num_in;
    logic [NW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          qbit;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign num_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign num_in  = num_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Shift in the next numerator bit and try to subtract the divisor.
    assign trial = {rem_in, num_in[NW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign qbit  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= qbit ? diff[DW-1:0] : trial[DW-1:0];
        num_q[k]  <= {num_in[NW-2:0], 1'b0};
        quo_q[k]  <= {quo_in[NW-2:0], qbit};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = quo_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

`default_nettype wire

@@ hw/rtl/i2c_scl_timing_calc.sv @@
// ----------------------------------------------------------------------------
// I2C SCL timing calculator
// Turns a requested I2C bit rate into SCL high/low counts, spike length,
// SDA hold count, speed mode and the bit rate actually achieved.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one bit-rate request per cycle while not stalled
//   (tdata holds baud_rate); the master stream returns one result per
//   request in order. cfg_we_i/cfg_wdata_i write the system clock frequency
//   in hertz; write it only while no request is in flight.
// Pipeline and throughput:
//   A request passes through 31 divider stages for the bit period, four
//   register stages (period floor and spike, hold multiply, split, clamps),
//   30 divider stages for the achieved rate and the output register. One
//   request is accepted per cycle while the output is not stalled.
// Reset:
//   All valid bits clear and the clock register returns to 125 MHz.
// Stall:
//   When the output holds a result that is not taken, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_scl_timing_calc
  import i2cstc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [28:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [22:0] baud_rate
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] params_valid, [2:1] speed_mode, [18:3] scl_high_count,
  // [34:19] scl_low_count, [42:35] spike_length, [58:43] sda_hold_count,
  // [83:59] achieved_baud
  output logic [87:0]      m_axis_tdata
);

  logic [ClkW-1:0] clk_hz_q;
  logic            en;
  logic            out_vld_q;
  logic [83:0]     out_data_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= ClkReset;
    end else if (cfg_we_i) begin
      clk_hz_q <= cfg_wdata_i;
    end
  end

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Input decode: period numerator and flags.
  logic [RateW-1:0] rate;
  logic             rate_ok;
  logic [1:0]       mode;
  logic             hstd;
  logic [30:0]      num1;
  logic             in_req;

  assign rate    = s_axis_tdata[RateW-1:0];
  assign rate_ok = (rate != '0);
  assign mode    = !rate_ok ? ModeInvalid :
                   (rate >= FastThreshold) ? ModeFast : ModeStandard;
  assign hstd    = (rate < HoldThreshold);
  assign num1    = 31'(clk_hz_q) + 31'(rate >> 1);
  assign in_req  = s_axis_tvalid && s_axis_tready;

  logic            d1_vld;
  logic [30:0]     d1_quo;
  logic [ClkW+3:0] d1_side;
  logic            d1_std;
  logic            d1_ok;
  logic [1:0]      d1_mode;
  logic [ClkW-1:0] d1_clk;

  i2cstc_div #(.NW(31), .DW(RateW), .SW(ClkW + 4)) u_div_period (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_req), .num_i(num1), .den_i(rate),
    .side_i({hstd, rate_ok, mode, clk_hz_q}), .valid_o(d1_vld), .quo_o(d1_quo),
    .side_o(d1_side)
  );

  assign {d1_std, d1_ok, d1_mode, d1_clk} = d1_side;

  // Stage B: period floor, spike length and the hold multiplier operand.
  logic [30:0] per_f;
  logic [30:0] per8;
  logic [26:0] spike_raw;
  logic [7:0]  spike_b;
  logic [30:0] hnum_b;
  logic [24:0] hx_b;

  assign per_f     = (d1_quo < MinPeriod) ? MinPeriod : d1_quo;
  assign per8      = per_f - 31'd8;
  assign spike_raw = per8[30:4];
  assign spike_b   = (spike_raw == '0) ? 8'd1 :
                     (spike_raw > 27'd255) ? 8'd255 : spike_raw[7:0];
  assign hnum_b    = 31'(d1_clk) + {1'b0, d1_clk, 1'b0};
  assign hx_b      = d1_std ? 25'(hnum_b[30:7]) : hnum_b[30:6];

  logic            b_vld_q;
  logic [30:0]     b_per8_q;
  logic [7:0]      b_spike_q;
  logic [24:0]     b_hx_q;
  logic            b_std_q;
  logic            b_ok_q;
  logic [1:0]      b_mode_q;
  logic [ClkW-1:0] b_clk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_per8_q  <= per8;
      b_spike_q <= spike_b;
      b_hx_q    <= hx_b;
      b_std_q   <= d1_std;
      b_ok_q    <= d1_ok;
      b_mode_q  <= d1_mode;
      b_clk_q   <= d1_clk;
    end
  end

  // Stage C: remaining period and the hold count multiply.
  logic [30:0] per2_c;
  logic [25:0] hmul_c;
  logic [50:0] hprod_c;

  assign per2_c  = b_per8_q - 31'(b_spike_q);
  assign hmul_c  = b_std_q ? 26'(HoldMulStd) : HoldMulFast;
  assign hprod_c = 51'(b_hx_q) * 51'(hmul_c);

  logic            c_vld_q;
  logic [30:0]     c_per2_q;
  logic [7:0]      c_spike_q;
  logic [9:0]      c_hq_q;
  logic            c_std_q;
  logic            c_ok_q;
  logic [1:0]      c_mode_q;
  logic [ClkW-1:0] c_clk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_per2_q  <= per2_c;
      c_spike_q <= b_spike_q;
      c_hq_q    <= hprod_c[50:41];
      c_std_q   <= b_std_q;
      c_ok_q    <= b_ok_q;
      c_mode_q  <= b_mode_q;
      c_clk_q   <= b_clk_q;
    end
  end

  // Stage D: three-fifths split of the period and the final hold shift.
  logic [64:0] lprod_d;
  logic [15:0] hold_d;

  assign lprod_d = 65'(c_per2_q) * 65'(LowMul3);
  assign hold_d  = 16'(c_std_q ? c_hq_q : (c_hq_q >> 3)) + 16'd1;

  logic            d_vld_q;
  logic [30:0]     d_low_q;
  logic [30:0]     d_per2_q;
  logic [7:0]      d_spike_q;
  logic [15:0]     d_hold_q;
  logic            d_ok_q;
  logic [1:0]      d_mode_q;
  logic [ClkW-1:0] d_clk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_low_q   <= lprod_d[64:34];
      d_per2_q  <= c_per2_q;
      d_spike_q <= c_spike_q;
      d_hold_q  <= hold_d;
      d_ok_q    <= c_ok_q;
      d_mode_q  <= c_mode_q;
      d_clk_q   <= c_clk_q;
    end
  end

  // Stage E: low and high clamps, hold limit and total period.
  logic [8:0]      lo_min;
  logic [8:0]      hi_min;
  logic [15:0]     low_c;
  logic [31:0]     high_raw;
  logic [15:0]     high_c;
  logic [15:0]     hold_lim;
  logic [15:0]     hold_c;
  logic [17:0]     total_c;

  assign lo_min   = 9'(d_spike_q) + 9'd7;
  assign hi_min   = 9'(d_spike_q) + 9'd5;
  assign low_c    = (d_low_q < 31'(lo_min)) ? 16'(lo_min) :
                    (d_low_q > 31'hFFFF) ? 16'hFFFF : d_low_q[15:0];
  assign high_raw = 32'(d_per2_q) - 32'(low_c);
  assign high_c   = (high_raw < 32'(hi_min)) ? 16'(hi_min) :
                    (high_raw > 32'(HighMax)) ? HighMax : high_raw[15:0];
  assign hold_lim = low_c - 16'd2;
  assign hold_c   = (d_hold_q > hold_lim) ? hold_lim : d_hold_q;
  assign total_c  = 18'(low_c) + 18'(high_c) + 18'(d_spike_q) + 18'd8;

  logic            e_vld_q;
  logic            e_ok_q;
  logic [1:0]      e_mode_q;
  logic [ClkW-1:0] e_clk_q;
  logic [15:0]     e_low_q;
  logic [15:0]     e_high_q;
  logic [7:0]      e_spike_q;
  logic [15:0]     e_hold_q;
  logic [17:0]     e_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_ok_q    <= d_ok_q;
      e_mode_q  <= d_mode_q;
      e_clk_q   <= d_clk_q;
      e_low_q   <= low_c;
      e_high_q  <= high_c;
      e_spike_q <= d_spike_q;
      e_hold_q  <= hold_c;
      e_total_q <= total_c;
    end
  end

  logic [29:0] num3;
  assign num3 = 30'(e_clk_q) + 30'(e_total_q >> 1);

  logic        d3_vld;
  logic [29:0] d3_quo;
  logic [58:0] d3_side;

  i2cstc_div #(.NW(30), .DW(18), .SW(59)) u_div_baud (
    .clk_i, .rst_ni, .en_i(en), .valid_i(e_vld_q), .num_i(num3),
    .den_i(e_total_q),
    .side_i({e_hold_q, e_spike_q, e_low_q, e_high_q, e_mode_q, e_ok_q}),
    .valid_o(d3_vld), .quo_o(d3_quo), .side_o(d3_side)
  );

  // Output register; a zero rate request gives an all-zero result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= d3_side[0] ? {d3_quo[24:0], d3_side} : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, out_data_q};

endmodule

`default_nettype wire

@@ tb/tb_i2c_scl_timing_calc.sv @@
// ----------------------------------------------------------------------------
// I2C SCL timing calculator testbench
// Streams bit-rate requests through the calculator under several system clock
// settings and compares every result field with a built-in timing predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_i2c_scl_timing_calc
  import i2cstc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxCycles = 2000000;
  localparam int unsigned DrainGap  = 150;

  typedef struct packed {
    logic [24:0] achieved;
    logic [15:0] hold;
    logic [7:0]  spike;
    logic [15:0] low;
    logic [15:0] high;
    logic [1:0]  mode;
    logic        valid;
  } timing_t;

  typedef struct {
    logic [22:0] rate;
    logic        has_golden;
    timing_t     golden;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [28:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;

  logic [28:0] clk_hz;
  timing_t     timing_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  i2c_scl_timing_calc u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always #6 clk_i = ~clk_i;

  // Predicts the SCL timing for one rate at the current clock setting.
  function automatic timing_t calc_timing(logic [22:0] rate, logic [28:0] fclk);
    logic [31:0] period, spike, low, high, hold, total;
    timing_t r;
    r = '0;
    if (rate == 0) return r;
    period = (32'(fclk) + 32'(rate) / 2) / 32'(rate);
    if (period < 23) period = 23;
    period = period - 8;
    spike = period / 16;
    if (spike < 1) spike = 1;
    if (spike > 255) spike = 255;
    period = period - spike;
    low = period * 3 / 5;
    if (low < spike + 7) low = spike + 7;
    if (low > 32'hffff) low = 32'hffff;
    high = period - low;
    if (high < spike + 5) high = spike + 5;
    if (high > 65525) high = 65525;
    if (rate < HoldThreshold) hold = 32'(fclk) * 3 / 10000000 + 1;
    else hold = 32'(fclk) * 3 / 25000000 + 1;
    if (hold > low - 2) hold = low - 2;
    total = low + high + spike + 8;
    r.valid = 1'b1;
    r.mode = (rate >= FastThreshold) ? ModeFast : ModeStandard;
    r.high = high[15:0];
    r.low = low[15:0];
    r.spike = spike[7:0];
    r.hold = hold[15:0];
    r.achieved = 25'((32'(fclk) + total / 2) / total);
    return r;
  endfunction

  // Cycle limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result checking against the oldest expected timing.
  always @(posedge clk_i) begin
    timing_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = timing_t'(m_axis_tdata[83:0]);
      if (timing_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = timing_q.pop_front();
        if (got !== want || m_axis_tdata[87:84] !== 4'b0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp v%0d m%0d h%0d l%0d s%0d hd%0d a%0d",
                     want.valid, want.mode, want.high, want.low, want.spike,
                     want.hold, want.achieved);
            $display("          got v%0d m%0d h%0d l%0d s%0d hd%0d a%0d",
                     got.valid, got.mode, got.high, got.low, got.spike,
                     got.hold, got.achieved);
          end
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic wait_idle();
    while (timing_q.size() != 0) @(negedge clk_i);
    repeat (DrainGap) @(negedge clk_i);
  endtask

  task automatic write_clock(logic [28:0] hz);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= hz;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    clk_hz = hz;
  endtask

  // Sends one rate request and records its expected timing on acceptance.
  task automatic send_rate(logic [22:0] rate);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, rate};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    timing_q.push_back(calc_timing(rate, clk_hz));
    @(negedge clk_i);
  endtask

  function automatic logic [22:0] rand_rate();
    case ($urandom_range(5))
      0: return 23'($urandom_range(1, 200));
      1: return 23'($urandom_range(50000, 1000000));
      2: return 23'($urandom_range(0, 5000000));
      3: return 23'($urandom);
      4: return 23'($urandom_range(1000, 120000));
      default: return 23'($urandom_range(400000, 800000));
    endcase
  endfunction

  dir_row_t dir_rows[$];

  initial begin
    logic [28:0] clocks[6];
    int unsigned phase;
    clk_hz = ClkReset;
    clocks = '{29'd0, 29'h1fffffff, 29'd500000000, 29'd8000000, 29'd48000000,
               29'd1000};
    // Directed rows: golden values only where plainly obvious.
    dir_rows.push_back('{23'd0, 1'b1, timing_t'('0)});
    dir_rows.push_back('{23'd1, 1'b0, timing_t'('0)});
    dir_rows.push_back('{23'h7fffff, 1'b0, timing_t'('0)});
    dir_rows.push_back('{23'd100000, 1'b0, timing_t'('0)});
    dir_rows.push_back('{23'd109999, 1'b0, timing_t'('0)});
    dir_rows.push_back('{23'd110000, 1'b0, timing_t'('0)});
    dir_rows.push_back('{23'd400000, 1'b0, timing_t'('0)});
    dir_rows.push_back('{23'd599999, 1'b0, timing_t'('0)});
    dir_rows.push_back('{23'd600000, 1'b0, timing_t'('0)});
    dir_rows.push_back('{23'd1000000, 1'b0, timing_t'('0)});
    dir_rows.push_back('{23'd5000000, 1'b0, timing_t'('0)});
    dir_rows.push_back('{23'h555555, 1'b0, timing_t'('0)});
    dir_rows.push_back('{23'h2aaaaa, 1'b0, timing_t'('0)});
    dir_rows.push_back('{23'd10, 1'b0, timing_t'('0)});

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset clock.
    foreach (dir_rows[i]) begin
      send_rate(dir_rows[i].rate);
      if (dir_rows[i].has_golden) timing_q[$] = dir_rows[i].golden;
    end
    s_axis_tvalid <= 1'b0;
    wait_idle();

    // Random part over several clock settings and idling phases.
    for (phase = 0; phase < 7; phase++) begin
      if (phase < 6) write_clock(clocks[phase]);
      else write_clock(29'($urandom_range(1000000, 500000000)));
      send_idle_pct = (phase < 2) ? 20 : (phase < 4) ? 79 : 0;
      recv_idle_pct = (phase < 2) ? 79 : (phase < 4) ? 20 : 0;
      send_rate(23'd0);
      send_rate(23'd1);
      send_rate(23'h7fffff);
      repeat (200) send_rate(rand_rate());
      s_axis_tvalid <= 1'b0;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
